// ===== hw/rtl/sobel_pkg.sv =====
// sobel_pkg: shared types and constants for the sobel edge magnitude core
// no dependencies
package sobel_pkg;

  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned PixBits   = 8;
  localparam int unsigned ColBits   = $clog2(MaxWidth);
  localparam int unsigned LwBits    = 12;
  localparam int unsigned FhBits    = 13;
  localparam int unsigned RowBits   = FhBits + 1;  // row runs one past the drain row
  localparam int unsigned GradBits  = PixBits + 3;  // |g| <= 4*max pixel
  localparam int unsigned SqBits    = 2 * GradBits + 1;
  localparam int unsigned QDepth    = 2;

  localparam logic [LwBits-1:0] LineWidthReset   = LwBits'(640);
  localparam logic [FhBits-1:0] FrameHeightReset = FhBits'(480);

  typedef enum logic [0:0] {
    CFG_LINE_WIDTH   = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  // back end sequencing
  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_PRE, ST_UPD, ST_SQ, ST_ROOT, ST_OUT
  } bst_e;

  // what the front end asks the back end to do with one item
  typedef struct packed {
    logic               pre_emit;   // emit old window as row end before update
    logic               pre_fend;   // that emit is the frame end
    logic               final_only; // final drain: emit only, no update
    logic               col_zero;   // load window with replicated column
    logic               post_emit;  // emit after the shift
    logic               y_ge1;      // write upper store
    logic               y_ge2;      // top comes from upper store
    logic               use_px;     // bottom is the pixel, not mid
    logic [ColBits-1:0] col;
    logic [PixBits-1:0] px;
  } cmd_t;

  // one window column: top, mid, bottom
  typedef struct packed {
    logic [PixBits-1:0] t;
    logic [PixBits-1:0] m;
    logic [PixBits-1:0] b;
  } wcol_t;

  typedef struct packed {
    wcol_t l;
    wcol_t c;
    wcol_t r;
  } win_t;

  typedef struct packed {
    logic [PixBits-1:0] mag;
    logic               row_end;
    logic               frame_end;
  } res_t;

endpackage

// ===== hw/rtl/sobel_ram.sv =====
// sobel_ram: generic single port ram with registered read
// no dependencies
module sobel_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== hw/rtl/sobel_front.sv =====
// sobel_front: raster position tracking and item classification
// depends on sobel_pkg
module sobel_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic                        op_i,
  input  logic [sobel_pkg::PixBits-1:0] px_i,
  input  logic [sobel_pkg::LwBits-1:0]  line_width_i,
  input  logic [sobel_pkg::FhBits-1:0]  frame_height_i,
  output logic                        cmd_valid_o,
  input  logic                        cmd_ready_i,
  output sobel_pkg::cmd_t             cmd_o
);
  import sobel_pkg::*;

  logic [ColBits-1:0] col_q, col_d;
  logic [RowBits-1:0] row_q, row_d;
  logic [LwBits-1:0]  w_eff;
  logic [FhBits-1:0]  h_eff;
  logic [ColBits-1:0] x, wlast;
  logic               drain_due, is_final, useful;
  cmd_t               c;

  always_comb begin
    w_eff = (line_width_i == '0) ? LwBits'(1) : line_width_i;
    if (w_eff > LwBits'(MaxWidth)) w_eff = LwBits'(MaxWidth);
    h_eff = (frame_height_i == '0) ? FhBits'(1) : frame_height_i;
    wlast = ColBits'(w_eff - LwBits'(1));
    x     = (col_q > wlast) ? wlast : col_q;
    drain_due = (row_q >= RowBits'(h_eff));
    is_final  = (row_q > RowBits'(h_eff));
    useful    = drain_due ? (op_i == OP_DRAIN) : (op_i == OP_PIXEL);

    c = '0;
    c.col        = x;
    c.px         = px_i;
    c.use_px     = !drain_due;
    c.y_ge1      = (row_q >= RowBits'(1));
    c.y_ge2      = (row_q >= RowBits'(2));
    c.final_only = is_final;
    c.col_zero   = (x == '0);
    c.pre_emit   = is_final || ((x == '0) && c.y_ge2);
    c.pre_fend   = is_final;
    c.post_emit  = !is_final && (x != '0) && c.y_ge1;

    col_d = col_q;
    row_d = row_q;
    if (is_final) begin
      col_d = '0;
      row_d = '0;
    end else if (x == wlast) begin
      col_d = '0;
      row_d = row_q + RowBits'(1);
    end else begin
      col_d = x + ColBits'(1);
    end
  end

  // ignored items are taken without queue space
  assign ready_o     = cmd_ready_i || !useful;
  assign cmd_valid_o = valid_i && useful;
  assign cmd_o       = c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (valid_i && useful && cmd_ready_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end
endmodule

// ===== hw/rtl/sobel_queue.sv =====
// sobel_queue: small command fifo between front and back
// depends on sobel_pkg
module sobel_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sobel_pkg::cmd_t in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sobel_pkg::cmd_t out_o
);
  import sobel_pkg::*;

  localparam int unsigned PtrBits = $clog2(QDepth);

  cmd_t               buf_q [QDepth];
  logic [PtrBits-1:0] wp_q, rp_q;
  logic [PtrBits:0]   cnt_q;
  logic               push, pop;

  assign in_ready_o  = (cnt_q != (PtrBits+1)'(QDepth));
  assign out_valid_o = (cnt_q != '0);
  assign out_o       = buf_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= in_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + PtrBits'(1);
      if (pop)  rp_q <= rp_q + PtrBits'(1);
      if (push && !pop) cnt_q <= cnt_q + (PtrBits+1)'(1);
      else if (pop && !push) cnt_q <= cnt_q - (PtrBits+1)'(1);
    end
  end
endmodule

// ===== hw/rtl/sobel_back.sv =====
// sobel_back: line stores, 3x3 window, gradient and magnitude search
// depends on sobel_pkg and sobel_ram
module sobel_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  output logic             cmd_ready_o,
  input  sobel_pkg::cmd_t  cmd_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output sobel_pkg::res_t  res_o
);
  import sobel_pkg::*;

  bst_e               st_q, st_d;
  cmd_t               cmd_q;
  win_t               win_q, win_d, emit_win;
  logic               do_post_q;
  logic               re_q;
  logic               fe_q;
  logic [PixBits-1:0] up_rd, mid_rd;
  logic               we;
  logic [ColBits-1:0] addr;
  logic [PixBits-1:0] top, mid, bot;
  logic signed [GradBits:0] gx, gy;
  logic [GradBits-1:0] ax_q, ay_q;
  logic [SqBits-1:0]  s_q;
  logic [PixBits-1:0] r_q;
  logic [2:0]         bit_q;
  logic [PixBits-1:0] cand;
  logic [PixBits:0]   dd;
  logic [2*PixBits+5:0] lhs;
  logic               start_mag;
  res_t               out_q;
  logic               out_v_q;

  assign addr = (st_q == ST_IDLE) ? cmd_i.col : cmd_q.col;
  assign we   = (st_q == ST_UPD);

  sobel_ram #(.Width(PixBits), .Depth(MaxWidth)) u_upper (
    .clk_i, .we_i(we && cmd_q.y_ge1), .addr_i(addr), .wdata_i(mid_rd), .rdata_o(up_rd)
  );
  sobel_ram #(.Width(PixBits), .Depth(MaxWidth)) u_middle (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(bot), .rdata_o(mid_rd)
  );

  // the registered read data holds while the address is unchanged and no write lands
  always_comb begin
    mid = mid_rd;
    top = cmd_q.y_ge2 ? up_rd : mid_rd;
    bot = cmd_q.use_px ? cmd_q.px : mid_rd;
    win_d = win_q;
    if (cmd_q.col_zero) begin
      win_d.l = '{t: top, m: mid, b: bot};
      win_d.c = '{t: top, m: mid, b: bot};
      win_d.r = '{t: top, m: mid, b: bot};
    end else begin
      win_d.l = win_q.c;
      win_d.c = win_q.r;
      win_d.r = '{t: top, m: mid, b: bot};
    end
  end

  // emit before the update uses columns centre,right,right; after it the new window
  always_comb begin
    emit_win = win_q;
    if (st_q == ST_PRE) begin
      emit_win.l = win_q.c;
      emit_win.c = win_q.r;
    end else if (st_q == ST_UPD) begin
      emit_win = win_d;
    end
  end

  // gradient magnitudes, registered before squaring
  always_comb begin
    gx = $signed({3'b0, emit_win.r.t} + {2'b0, emit_win.r.m, 1'b0} + {3'b0, emit_win.r.b})
       - $signed({3'b0, emit_win.l.t} + {2'b0, emit_win.l.m, 1'b0} + {3'b0, emit_win.l.b});
    gy = $signed({3'b0, emit_win.l.t} + {2'b0, emit_win.c.t, 1'b0} + {3'b0, emit_win.r.t})
       - $signed({3'b0, emit_win.l.b} + {2'b0, emit_win.c.b, 1'b0} + {3'b0, emit_win.r.b});
  end

  // one bit of the root per cycle
  always_comb begin
    cand = r_q | (PixBits'(1) << bit_q);
    dd   = {cand, 1'b0} - (PixBits+1)'(1);
    lhs  = ((2*PixBits+6)'(dd) * (2*PixBits+6)'(dd)) << 3;
  end

  assign start_mag = (st_q == ST_PRE) || (st_q == ST_UPD && cmd_q.post_emit);

  always_comb begin
    st_d = st_q;
    cmd_ready_o = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) st_d = ST_READ;
      end
      ST_READ: st_d = cmd_q.pre_emit ? ST_PRE : ST_UPD;
      ST_PRE:  st_d = ST_SQ;
      ST_UPD:  st_d = cmd_q.post_emit ? ST_SQ : ST_IDLE;
      ST_SQ:   st_d = ST_ROOT;
      ST_ROOT: if (bit_q == '0) st_d = ST_OUT;
      ST_OUT: begin
        if (!out_v_q) st_d = (do_post_q || cmd_q.final_only) ? ST_IDLE : ST_UPD;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      win_q     <= '0;
      do_post_q <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_IDLE && cmd_valid_i) do_post_q <= 1'b0;
      if (st_q == ST_UPD) begin
        win_q     <= win_d;
        do_post_q <= cmd_q.post_emit;
      end
      if (st_q == ST_ROOT && bit_q == '0) out_v_q <= 1'b1;
      else if (out_v_q && res_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && cmd_valid_i) cmd_q <= cmd_i;
    if (start_mag) begin
      ax_q <= GradBits'(gx < 0 ? -gx : gx);
      ay_q <= GradBits'(gy < 0 ? -gy : gy);
      re_q <= (st_q == ST_PRE);
      fe_q <= (st_q == ST_PRE) && cmd_q.pre_fend;
    end
    if (st_q == ST_SQ) begin
      s_q   <= SqBits'(ax_q) * SqBits'(ax_q) + SqBits'(ay_q) * SqBits'(ay_q);
      r_q   <= '0;
      bit_q <= 3'(PixBits - 1);
    end
    if (st_q == ST_ROOT) begin
      if (SqBits'(lhs) <= s_q) r_q <= cand;
      if (bit_q != '0) bit_q <= bit_q - 3'd1;
    end
    if (st_q == ST_ROOT && bit_q == '0) begin
      out_q.mag       <= (SqBits'(lhs) <= s_q) ? cand : r_q;
      out_q.row_end   <= re_q;
      out_q.frame_end <= fe_q;
    end
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;
endmodule

// ===== hw/rtl/sobel_edge_magnitude_core.sv =====
// sobel_edge_magnitude_core: top level of the streaming sobel edge magnitude block
// depends on sobel_pkg, sobel_front, sobel_queue, sobel_back, sobel_ram
//
// channel   direction  tdata / payload                        tuser / tlast
// s_axis    in         [7:0] pixel                              tuser [0] op
// m_axis    out        [7:0] magnitude                          tlast row_end, tuser [0] frame_end
// cfg       in         index 0 line_width, 1 frame_height       -
//
// back end: an item with one result holds the back end through the serial eight
// step square root and the output hand-off, and longer when a row end result comes
// before the window update; an item with no result only reads and updates the
// window, and ignored items are taken without entering the queue
// reset: position counters, window and handshakes clear; line stores are not cleared
// stalls: the front keeps accepting into a two entry queue, until it is full, while the back
// end works or waits on m_axis_tready
module sobel_edge_magnitude_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  logic [0:0]  s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] magnitude
  output logic        m_axis_tlast,   // row_end
  output logic [0:0]  m_axis_tuser,   // [0] frame_end
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);
  import sobel_pkg::*;

  logic [LwBits-1:0] line_width_q;
  logic [FhBits-1:0] frame_height_q;
  logic              f_valid, f_ready, b_valid, b_ready;
  cmd_t              f_cmd, b_cmd;
  res_t              res;

  // configuration registers, always writable
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= LineWidthReset;
      frame_height_q <= FrameHeightReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LINE_WIDTH:   line_width_q   <= cfg_data_i[LwBits-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sobel_front u_front (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .op_i(s_axis_tuser[0]), .px_i(s_axis_tdata),
    .line_width_i(line_width_q), .frame_height_i(frame_height_q),
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd)
  );

  sobel_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_i(f_cmd),
    .out_valid_o(b_valid), .out_ready_i(b_ready), .out_o(b_cmd)
  );

  sobel_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(b_valid), .cmd_ready_o(b_ready), .cmd_i(b_cmd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = res.mag;
  assign m_axis_tlast = res.row_end;
  assign m_axis_tuser = res.frame_end;

  // a frame end is always a row end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("frame end without row end");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable({m_axis_tuser, m_axis_tlast, m_axis_tdata}))
    else $error("result changed under stall");

  // a full queue is never empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !f_ready |-> b_valid)
    else $error("queue full but empty");
endmodule
